FILE: hw/rtl/alias_table_sampler_assert.svh
// Assertion macros used by the alias table sampler back end.
`ifndef ALIAS_TABLE_SAMPLER_ASSERT_SVH
`define ALIAS_TABLE_SAMPLER_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, clocked on clk, disabled in reset.
`define ATS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, clocked on clk, disabled in reset.
`define ATS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ATS_ASSERT_NOW(lbl, ante, cons, msg)
`define ATS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/ats_pkg.sv
// Types, constants and helpers for the alias table sampler.
package ats_pkg;

    localparam int MAX_N     = 256;
    localparam int IDX_W     = 8;
    localparam int N_W       = 9;
    localparam int WGT_W     = 16;
    localparam int RND_W     = 16;
    localparam int FRAC_W    = 16;
    localparam int SUM_W     = 24;
    localparam int PROB_W    = 25;
    localparam int DIVD_W    = SUM_W + FRAC_W;
    localparam int QDEPTH    = 2;

    localparam logic [N_W-1:0]    N_MAX   = N_W'(MAX_N);
    localparam logic [PROB_W-1:0] ONE_FIX = PROB_W'(1) << FRAC_W;
    localparam logic [5:0]        DIV_LAST = 6'(DIVD_W - 1);

    // Error codes
    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_ZERO_SUM = 2'd1;
    localparam logic [1:0] ERR_NO_TABLE = 2'd2;

    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] weight_index;
        logic [WGT_W-1:0] weight;
        logic             last_weight;
        logic [RND_W-1:0] rand_bucket;
        logic [RND_W-1:0] rand_accept;
    } ats_in_t;

    typedef struct packed {
        logic [IDX_W-1:0] sample;
        logic             sample_valid;
        logic             table_ready;
        logic [1:0]       error_code;
    } ats_out_t;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_BUILD  = 2'd1,
        CMD_SAMPLE = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [IDX_W-1:0] index;
        logic [WGT_W-1:0] weight;
        logic [RND_W-1:0] u1;
        logic [RND_W-1:0] u2;
    } ats_cmd_t;

    // Queue status seen by the front and back end
    typedef struct packed {
        logic full;
        logic empty;
    } ats_qstat_t;

    // Clamp the element count register into 1..MAX_N
    function automatic logic [N_W-1:0] eff_n(input logic [N_W-1:0] v);
        logic [N_W-1:0] r;
        r = v;
        if (v == '0) r = N_W'(1);
        else if (v > N_MAX) r = N_MAX;
        return r;
    endfunction

endpackage

FILE: hw/rtl/ats_chan_if.sv
// Valid/ready channel carrying one item of a given payload type.
interface ats_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/alias_table_sampler.sv
// Alias table sampler: build from loaded weights, then draw samples.
// A plain load goes through the queue to the result register; a sample
// passes the queue, bucket multiply, prob/alias table read and compare.
// One command runs at a time; the next is taken from the queue when idle.
// A build sums the weights, scales each one with the 40-step restoring
// divider, then pairs small with large entries and fills the leftovers.
// Reset clears control state, counts and the table ready flag; n resets to 256.
module alias_table_sampler
    import ats_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [N_W-1:0] cfg_wdata,
    ats_chan_if.sink       cmd,
    ats_chan_if.source     res
);

    logic [N_W-1:0] num_elements_reg;
    logic           push, pop;
    ats_cmd_t       push_cmd, head;
    ats_qstat_t     qstat;

    // element count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            num_elements_reg <= N_MAX;
        else if (cfg_we)
            num_elements_reg <= cfg_wdata;
    end

    ats_front u_front (
        .cmd      (cmd),
        .q_full   (qstat.full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    ats_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (qstat)
    );

    ats_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .n_eff    (eff_n(num_elements_reg)),
        .cfg_clr  (cfg_we),
        .head     (head),
        .qstat    (qstat),
        .pop      (pop),
        .res      (res)
    );

endmodule

FILE: hw/rtl/ats_front.sv
// Front end: accepts input items and classifies them into commands.
module ats_front
    import ats_pkg::*;
(
    ats_chan_if.sink   cmd,
    input  logic       q_full,
    output logic       push,
    output ats_cmd_t   push_cmd
);

    // accept whenever the queue has room
    assign cmd.ready = !q_full;
    assign push      = cmd.valid && !q_full;

    // decode item into a back end command
    always_comb
    begin
        push_cmd.index  = cmd.data.weight_index;
        push_cmd.weight = cmd.data.weight;
        push_cmd.u1     = cmd.data.rand_bucket;
        push_cmd.u2     = cmd.data.rand_accept;
        if (cmd.data.op)
            push_cmd.kind = CMD_SAMPLE;
        else if (cmd.data.last_weight)
            push_cmd.kind = CMD_BUILD;
        else
            push_cmd.kind = CMD_LOAD;
    end

endmodule

FILE: hw/rtl/ats_queue.sv
// Short command queue between front and back end.
module ats_queue
    import ats_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  ats_cmd_t   push_cmd,
    input  logic       pop,
    output ats_cmd_t   head,
    output ats_qstat_t stat
);

    localparam int PW = $clog2(QDEPTH);

    ats_cmd_t        slot_reg [QDEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     count_reg;

    assign head       = slot_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == (PW+1)'(QDEPTH));
    assign stat.empty = (count_reg == '0);

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            if (push && !pop)
                count_reg <= count_reg + (PW+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (PW+1)'(1);
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

FILE: hw/rtl/ats_back.sv
// Back end: weight store, table build sequencer and sampler.
`include "alias_table_sampler_assert.svh"
module ats_back
    import ats_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [N_W-1:0] n_eff,
    input  logic           cfg_clr,
    input  ats_cmd_t       head,
    input  ats_qstat_t     qstat,
    output logic           pop,
    ats_chan_if.source     res
);

    typedef enum logic [16:0] {
        S_IDLE    = 17'd1,
        S_SUM_RD  = 17'd2,
        S_SUM_ACC = 17'd4,
        S_SC_RD   = 17'd8,
        S_SC_MUL  = 17'd16,
        S_SC_DIV  = 17'd32,
        S_SC_PUSH = 17'd64,
        S_P_CHK   = 17'd128,
        S_P_RD1   = 17'd256,
        S_P_RD2   = 17'd512,
        S_P_UPD   = 17'd1024,
        S_F_CHK   = 17'd2048,
        S_F_RD    = 17'd4096,
        S_F_WR    = 17'd8192,
        S_SMP_RD  = 17'd16384,
        S_SMP_DO  = 17'd32768,
        S_SPARE   = 17'd65536
    } state_t;

    state_t              state_reg, state_next;
    logic [N_W-1:0]      idx_reg, sc_reg, lc_reg, n_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [DIVD_W-1:0]   div_reg;
    logic [SUM_W-1:0]    rem_reg;
    logic [PROB_W-1:0]   q_reg;
    logic [5:0]          cnt_reg;
    logic [IDX_W-1:0]    bucket_reg;
    logic [RND_W-1:0]    u2_reg;
    logic                ready_reg;
    logic                out_valid_reg;
    ats_out_t            out_data_reg;

    // memories and their registered read data
    logic [WGT_W-1:0]    weight_mem [MAX_N];
    logic [PROB_W-1:0]   prob_mem   [MAX_N];
    logic [IDX_W-1:0]    alias_mem  [MAX_N];
    logic [IDX_W-1:0]    small_mem  [MAX_N];
    logic [IDX_W-1:0]    large_mem  [MAX_N];
    logic [WGT_W-1:0]    w_rd_reg;
    logic [PROB_W-1:0]   pa_rd_reg, pb_rd_reg;
    logic [IDX_W-1:0]    a_rd_reg, s_rd_reg, l_rd_reg;

    logic                start, emit, last_idx, rem_ge;
    ats_out_t            emit_data;
    logic [N_W-1:0]      idx_inc, sc_m1, lc_m1;
    logic [SUM_W-1:0]    sum_add;
    logic [SUM_W:0]      rem_sh, rem_sub;
    logic [PROB_W-1:0]   new_p;
    logic [WGT_W+N_W-1:0] prod_w;
    logic [RND_W+N_W-1:0] prod_u;
    logic [IDX_W-1:0]    pa_addr;
    logic                prob_we, small_we, large_we, alias_we;
    logic [IDX_W-1:0]    prob_waddr, small_waddr, large_waddr;
    logic [PROB_W-1:0]   prob_wdata;
    logic [IDX_W-1:0]    small_wdata, large_wdata;

    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;

    // shared arithmetic; a new item may start as the held result leaves
    assign start    = (state_reg == S_IDLE) && !qstat.empty
                      && (!out_valid_reg || res.ready);
    assign pop      = start;
    assign idx_inc  = idx_reg + N_W'(1);
    assign sc_m1    = sc_reg - N_W'(1);
    assign lc_m1    = lc_reg - N_W'(1);
    assign last_idx = (idx_inc == n_reg);
    assign sum_add  = sum_reg + SUM_W'(w_rd_reg);
    assign rem_sh   = {rem_reg, div_reg[DIVD_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, sum_reg});
    assign rem_sub  = rem_sh - {1'b0, sum_reg};
    assign new_p    = pb_rd_reg + pa_rd_reg - ONE_FIX;
    assign prod_w   = w_rd_reg * n_reg;
    assign prod_u   = head.u1 * n_eff;
    assign pa_addr  = (state_reg == S_SMP_RD) ? bucket_reg : s_rd_reg;

    // sequencer and result formation
    always_comb
    begin
        state_next = state_reg;
        emit       = 1'b0;
        emit_data  = '{sample: '0, sample_valid: 1'b0, table_ready: ready_reg,
                       error_code: ERR_OK};
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (head.kind)
                        CMD_BUILD:
                            state_next = S_SUM_RD;
                        CMD_SAMPLE:
                        begin
                            if (ready_reg)
                                state_next = S_SMP_RD;
                            else
                            begin
                                emit                 = 1'b1;
                                emit_data.error_code = ERR_NO_TABLE;
                            end
                        end
                        default:
                            emit = 1'b1;
                    endcase
                end
            end
            S_SUM_RD:
                state_next = S_SUM_ACC;
            S_SUM_ACC:
            begin
                if (last_idx)
                begin
                    if (sum_add == '0)
                    begin
                        emit                  = 1'b1;
                        emit_data.table_ready = 1'b0;
                        emit_data.error_code  = ERR_ZERO_SUM;
                        state_next            = S_IDLE;
                    end
                    else
                        state_next = S_SC_RD;
                end
                else
                    state_next = S_SUM_RD;
            end
            S_SC_RD:
                state_next = S_SC_MUL;
            S_SC_MUL:
                state_next = S_SC_DIV;
            S_SC_DIV:
                if (cnt_reg == DIV_LAST)
                    state_next = S_SC_PUSH;
            S_SC_PUSH:
                state_next = last_idx ? S_P_CHK : S_SC_RD;
            S_P_CHK:
                state_next = (sc_reg != '0 && lc_reg != '0) ? S_P_RD1 : S_F_CHK;
            S_P_RD1:
                state_next = S_P_RD2;
            S_P_RD2:
                state_next = S_P_UPD;
            S_P_UPD:
                state_next = S_P_CHK;
            S_F_CHK:
            begin
                if (sc_reg != '0 || lc_reg != '0)
                    state_next = S_F_RD;
                else
                begin
                    emit                  = 1'b1;
                    emit_data.table_ready = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            S_F_RD:
                state_next = S_F_WR;
            S_F_WR:
                state_next = S_F_CHK;
            S_SMP_RD:
                state_next = S_SMP_DO;
            S_SMP_DO:
            begin
                emit                   = 1'b1;
                emit_data.sample_valid = 1'b1;
                emit_data.sample       = ({9'd0, u2_reg} < pa_rd_reg) ? bucket_reg
                                                                    : a_rd_reg;
                state_next             = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // memory write controls
    always_comb
    begin
        prob_we     = 1'b0;
        prob_waddr  = idx_reg[IDX_W-1:0];
        prob_wdata  = q_reg;
        small_we    = 1'b0;
        small_waddr = sc_reg[IDX_W-1:0];
        small_wdata = idx_reg[IDX_W-1:0];
        large_we    = 1'b0;
        large_waddr = lc_reg[IDX_W-1:0];
        large_wdata = idx_reg[IDX_W-1:0];
        alias_we    = (state_reg == S_P_UPD);
        case (state_reg)
            S_SC_PUSH:
            begin
                prob_we = 1'b1;
                if (q_reg < ONE_FIX)
                    small_we = 1'b1;
                else
                    large_we = 1'b1;
            end
            S_P_UPD:
            begin
                prob_we    = 1'b1;
                prob_waddr = l_rd_reg;
                prob_wdata = new_p;
                if (new_p < ONE_FIX)
                begin
                    small_we    = 1'b1;
                    small_waddr = sc_m1[IDX_W-1:0];
                    small_wdata = l_rd_reg;
                end
                else
                begin
                    large_we    = 1'b1;
                    large_waddr = lc_m1[IDX_W-1:0];
                    large_wdata = l_rd_reg;
                end
            end
            S_F_WR:
            begin
                prob_we    = 1'b1;
                prob_waddr = (sc_reg == '0) ? l_rd_reg : s_rd_reg;
                prob_wdata = ONE_FIX;
            end
            default:
                prob_we = 1'b0;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            sc_reg        <= '0;
            lc_reg        <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
            if (cfg_clr)
                ready_reg <= 1'b0;
            else if (emit)
                ready_reg <= emit_data.table_ready;
            case (state_reg)
                S_IDLE:
                    idx_reg <= '0;
                S_SUM_ACC:
                begin
                    idx_reg <= last_idx ? '0 : idx_inc;
                    sc_reg  <= '0;
                    lc_reg  <= '0;
                end
                S_SC_MUL:
                    cnt_reg <= '0;
                S_SC_DIV:
                    cnt_reg <= cnt_reg + 6'd1;
                S_SC_PUSH:
                begin
                    idx_reg <= idx_inc;
                    if (q_reg < ONE_FIX)
                        sc_reg <= sc_reg + N_W'(1);
                    else
                        lc_reg <= lc_reg + N_W'(1);
                end
                S_P_UPD:
                begin
                    if (new_p < ONE_FIX)
                        lc_reg <= lc_m1;
                    else
                        sc_reg <= sc_m1;
                end
                S_F_WR:
                begin
                    if (sc_reg != '0)
                        sc_reg <= sc_m1;
                    else
                        lc_reg <= lc_m1;
                end
                default:
                    cnt_reg <= cnt_reg;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (emit)
            out_data_reg <= emit_data;
        case (state_reg)
            S_IDLE:
            begin
                sum_reg    <= '0;
                n_reg      <= n_eff;
                bucket_reg <= prod_u[RND_W +: IDX_W];
                u2_reg     <= head.u2;
            end
            S_SUM_ACC:
                sum_reg <= sum_add;
            S_SC_MUL:
            begin
                div_reg <= {prod_w[SUM_W-1:0], FRAC_W'(0)};
                rem_reg <= '0;
                q_reg   <= '0;
            end
            S_SC_DIV:
            begin
                div_reg <= {div_reg[DIVD_W-2:0], 1'b0};
                rem_reg <= rem_ge ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
                q_reg   <= {q_reg[PROB_W-2:0], rem_ge};
            end
            default:
                sum_reg <= sum_reg;
        endcase
    end

    // weight store
    always_ff @(posedge clk)
    begin
        if (start && head.kind != CMD_SAMPLE)
            weight_mem[head.index] <= head.weight;
        w_rd_reg <= weight_mem[idx_reg[IDX_W-1:0]];
    end

    // probability table, two read ports
    always_ff @(posedge clk)
    begin
        if (prob_we)
            prob_mem[prob_waddr] <= prob_wdata;
        pa_rd_reg <= prob_mem[pa_addr];
        pb_rd_reg <= prob_mem[l_rd_reg];
    end

    // alias table
    always_ff @(posedge clk)
    begin
        if (alias_we)
            alias_mem[s_rd_reg] <= l_rd_reg;
        a_rd_reg <= alias_mem[bucket_reg];
    end

    // small and large stacks, read at the top entry
    always_ff @(posedge clk)
    begin
        if (small_we)
            small_mem[small_waddr] <= small_wdata;
        s_rd_reg <= small_mem[sc_m1[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (large_we)
            large_mem[large_waddr] <= large_wdata;
        l_rd_reg <= large_mem[lc_m1[IDX_W-1:0]];
    end

    // checks
    `ATS_ASSERT_NOW(a_emit_slot_free, emit, !out_valid_reg || res.ready,
                    "result overwrote pending item")
    `ATS_ASSERT_NOW(a_pair_nonempty, state_reg == S_P_UPD, sc_reg != '0 && lc_reg != '0,
                    "pairing with an empty stack")
    `ATS_ASSERT_NOW(a_sample_has_table, emit && emit_data.sample_valid,
                    emit_data.table_ready && emit_data.error_code == ERR_OK,
                    "sample drawn without a table")
    `ATS_ASSERT_NEXT(a_div_runs, state_reg == S_SC_MUL, state_reg == S_SC_DIV,
                     "divider did not start after scaling product")

endmodule
